// ===== rtl/upd_pkg.sv =====
// ----------------------------------------------------------------------------
// upd_pkg
// Types, character codes and helper functions shared by the percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [3:0] HEX_TEN    = 4'd10;

	// command queue geometry
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_run_end;
		logic       out_stream_end;
	} out_t;

	// escape tracking; the unused code behaves as idle
	typedef enum logic [1:0] {
		ESC_IDLE  = 2'd0,
		ESC_PCT   = 2'd1,
		ESC_DIGIT = 2'd2
	} esc_phase_t;

	// one queued command: up to three result bytes for one input item
	typedef struct packed {
		logic [1:0]      count;
		logic [2:0][7:0] bytes;
		logic            last;
	} cmd_t;

	typedef struct packed {
		logic nonempty;
		logic full;
	} q_stat_t;

	typedef struct packed {
		esc_phase_t phase;
	} front_stat_t;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
			(c >= 8'h61 && c <= 8'h66);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] v;
		v = 8'h00;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c - 8'h30;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = c - 8'h41 + {4'h0, HEX_TEN};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = c - 8'h61 + {4'h0, HEX_TEN};
		end
		return v[3:0];
	endfunction

endpackage

// ===== rtl/upd_front.sv =====
// ----------------------------------------------------------------------------
// upd_front
// Accepts input items, tracks the escape state and builds one command of
// zero to three result bytes per item.
// ----------------------------------------------------------------------------
module upd_front import upd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        acc,
	input  in_t         in_data,
	output logic        push,
	output cmd_t        cmd,
	output front_stat_t stat
);

	esc_phase_t phase_q, phase_d;
	logic [7:0] held_q, held_d;

	logic [7:0] b;
	logic       last;
	logic       hex;

	assign b    = in_data.in_byte;
	assign last = in_data.in_last;
	assign hex  = is_hex(b);

	// next state
	always_comb begin
		phase_d = ESC_IDLE;
		held_d  = held_q;
		unique case (phase_q)
			ESC_PCT: begin
				if (hex && !last) begin
					phase_d = ESC_DIGIT;
					held_d  = b;
				end else if (!hex && b == CH_PERCENT && !last) begin
					phase_d = ESC_PCT;
				end
			end
			ESC_DIGIT: begin
				held_d = 8'h00;
				if (!hex && b == CH_PERCENT && !last) begin
					phase_d = ESC_PCT;
				end
			end
			default: begin
				if (b == CH_PERCENT && !last) begin
					phase_d = ESC_PCT;
				end
			end
		endcase
		if (last) begin
			held_d = 8'h00;
		end
	end

	// command build
	always_comb begin
		logic fresh;
		fresh      = 1'b0;
		cmd.count  = 2'd0;
		cmd.bytes  = '0;
		cmd.last   = last;
		unique case (phase_q)
			ESC_PCT: begin
				if (hex) begin
					if (last) begin
						cmd.bytes[0] = CH_PERCENT;
						cmd.bytes[1] = b;
						cmd.count    = 2'd2;
					end
				end else begin
					cmd.bytes[0] = CH_PERCENT;
					cmd.count    = 2'd1;
					fresh        = 1'b1;
				end
			end
			ESC_DIGIT: begin
				if (hex) begin
					cmd.bytes[0] = {hex_val(held_q), hex_val(b)};
					cmd.count    = 2'd1;
				end else begin
					cmd.bytes[0] = CH_PERCENT;
					cmd.bytes[1] = held_q;
					cmd.count    = 2'd2;
					fresh        = 1'b1;
				end
			end
			default: begin
				fresh = 1'b1;
			end
		endcase
		if (fresh) begin
			if (b == CH_PERCENT) begin
				if (last) begin
					cmd.bytes[cmd.count] = CH_PERCENT;
					cmd.count            = cmd.count + 2'd1;
				end
			end else begin
				cmd.bytes[cmd.count] = (b == CH_PLUS) ? CH_SPACE : b;
				cmd.count            = cmd.count + 2'd1;
			end
		end
	end

	assign push       = acc && (cmd.count != 2'd0);
	assign stat.phase = phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ESC_IDLE;
			held_q  <= 8'h00;
		end else if (acc) begin
			phase_q <= phase_d;
			held_q  <= held_d;
		end
	end

endmodule

// ===== rtl/upd_queue.sv =====
// ----------------------------------------------------------------------------
// upd_queue
// Short command queue between front and back, flop based.
// ----------------------------------------------------------------------------
module upd_queue import upd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    wr_cmd,
	input  logic    pop,
	output cmd_t    head,
	output q_stat_t stat
);

	cmd_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;

	assign head          = mem_q[rd_ptr_q];
	assign stat.nonempty = (count_q != '0);
	assign stat.full     = (count_q == (QAW+1)'(QDEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + (QAW+1)'(1);
				2'b01:   count_q <= count_q - (QAW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/upd_back.sv =====
// ----------------------------------------------------------------------------
// upd_back
// Walks the head command one byte per cycle, while the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module upd_back import upd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    head,
	input  q_stat_t q_stat,
	output logic    pop,
	output logic    out_valid,
	input  logic    out_ready,
	output out_t    out_data
);

	logic [1:0] idx_q;
	logic       valid_q;
	out_t       data_q;
	logic       load;
	logic       take;
	logic       run_end;

	assign load    = !valid_q || out_ready;
	assign take    = load && q_stat.nonempty;
	assign run_end = (idx_q == head.count - 2'd1);
	assign pop     = take && run_end;

	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk) begin
		if (take) begin
			data_q.out_byte       <= head.bytes[idx_q];
			data_q.out_run_end    <= run_end;
			data_q.out_stream_end <= run_end && head.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= q_stat.nonempty;
			end
			if (take) begin
				idx_q <= run_end ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

endmodule

// ===== rtl/url_percent_decoder.sv =====
// ----------------------------------------------------------------------------
// url_percent_decoder
// Streaming form-urlencoded decoder: %XY to byte, '+' to space, others pass.
// ----------------------------------------------------------------------------
//
//  channel | signals                          | item
//  --------+----------------------------------+--------------------------------
//  in      | in_valid, in_ready, in_data      | one encoded byte + end flag
//  out     | out_valid, out_ready, out_data   | one decoded byte + end flags
//
//  Input items are taken one per cycle while the command queue has room.
//  Each item yields 0..3 results; the back end emits one result per cycle
//  while the output is not stalled, via the command queue and output register.
//  The four-entry command queue plus the output register absorb bursts.
//  Reset clears the escape state, queue pointers and output valid.
//  A stalled output fills the queue, then drops in_ready.
//
module url_percent_decoder import upd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	logic        acc;
	logic        push;
	logic        pop;
	cmd_t        cmd;
	cmd_t        head;
	q_stat_t     q_stat;
	front_stat_t f_stat;

	// ready only depends on registered queue fill
	assign in_ready = !q_stat.full;
	assign acc      = in_valid && in_ready;

	// front: escape tracking, at most one command per item
	upd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (acc),
		.in_data (in_data),
		.push    (push),
		.cmd     (cmd),
		.stat    (f_stat)
	);

	// queue decouples front and back stalls
	upd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (cmd),
		.pop    (pop),
		.head   (head),
		.stat   (q_stat)
	);

	// back: serialize command bytes into the output register
	upd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// end of string always leaves the escape tracker idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		acc && in_data.in_last |=> f_stat.phase == ESC_IDLE)
		else $error("escape state not idle after end of string");

	// stream end only on the last result of an item
	a_end_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!out_data.out_stream_end || out_data.out_run_end))
		else $error("stream end without run end");

	// a nonempty queue always has the output valid next cycle
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.nonempty |=> out_valid)
		else $error("queued command not presented");

endmodule
